[rtl/packed_rgb444_span_fill_top_macros.svh]
// Assertion macros for the packed RGB444 span fill block.
// Used by the top level only; NO_ASSERTIONS removes every check.
`ifndef PACKED_RGB444_SPAN_FILL_TOP_MACROS_SVH
`define PACKED_RGB444_SPAN_FILL_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PRSF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prsf: same-cycle check failed");
`define PRSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prsf: next-cycle check failed");
`else
`define PRSF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define PRSF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/prsf_pkg.sv]
// Shared types and constants for the packed RGB444 span fill block.
// No dependencies.
`timescale 1ns / 1ps

package prsf_pkg;

   typedef struct packed {
      logic [9:0] start_x;
      logic [9:0] row_y;
      logic [9:0] span_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [17:0] byte_address;
      logic [7:0]  first_byte;
      logic [7:0]  middle_byte;
      logic [7:0]  third_byte;
      logic [5:0]  nibble_enable;
      logic        last_write;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic check;
      logic emit_error;
      logic add_base;
      logic emit_write;
   } ctl_cmd_type;

   typedef struct packed {
      logic fail;
      logic last;
   } dp_status_type;

   localparam logic [2:0] ST_OK             = 3'd0;
   localparam logic [2:0] ST_INVALID_CANVAS = 3'd1;
   localparam logic [2:0] ST_BAD_X          = 3'd2;
   localparam logic [2:0] ST_BAD_Y          = 3'd3;
   localparam logic [2:0] ST_ZERO_LENGTH    = 3'd4;
   localparam logic [2:0] ST_BAD_LENGTH     = 3'd5;
   localparam logic [2:0] ST_END_COLUMN     = 3'd6;

   localparam logic [1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_CANVAS_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PIXEL_COLOR   = 2'd2;

   localparam logic [5:0] NIB_PAIR = 6'h3f;
   localparam logic [5:0] NIB_EVEN = 6'h38;
   localparam logic [5:0] NIB_ODD  = 6'h07;

endpackage

[rtl/prsf_ctrl.sv]
// Sequencer for the span fill: check, address set-up, one write per cycle.
// Depends on prsf_pkg.
`timescale 1ns / 1ps

module prsf_ctrl
   import prsf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type dp_status,
   output logic          busy,
   output ctl_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_BASE  = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = dp_status.fail ? S_IDLE : S_BASE;
         end
         S_BASE: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (dp_status.last) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd.load       = (state_ff == S_IDLE) && start;
      cmd.check      = (state_ff == S_CHECK);
      cmd.emit_error = (state_ff == S_CHECK) && dp_status.fail;
      cmd.add_base   = (state_ff == S_BASE);
      cmd.emit_write = (state_ff == S_EMIT);
   end

endmodule

[rtl/prsf_datapath.sv]
// Datapath: canvas registers, bound checks, line base multiply, pair walker
// and the result register. Depends on prsf_pkg; driven by prsf_ctrl.
`timescale 1ns / 1ps

module prsf_datapath
   import prsf_pkg::*;
#(
   parameter int MAX_WIDTH = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_payload,
   input  ctl_cmd_type   cmd,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [11:0]   csr_data,
   output dp_status_type dp_status,
   output logic          rsp_strobe,
   output rsp_type       rsp_payload
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int LW = WW + 1;

   logic [7:0]  width_ff;
   logic [9:0]  height_ff;
   logic [11:0] color_ff;

   logic [9:0]  x_ff, y_ff, w_ff;
   logic [17:0] prod_ff, addr_ff;
   logic [XW-1:0] rem_ff;
   logic          odd_ff;
   rsp_type       rsp_ff;
   logic          strobe_ff;

   logic [8:0]    cw_ext, max_ext, clamp;
   logic [WW-1:0] wid;
   logic [LW-1:0] line_off;
   logic [9:0]    hgt;
   logic [10:0]   end_sum;
   logic [2:0]    chk;
   logic [LW+9:0] product;
   logic          take_one;
   logic [XW:0]   rem_wide;
   logic [5:0]    nib;
   rsp_type       err_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         color_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  width_ff  <= csr_data[7:0];
            CSR_CANVAS_HEIGHT: height_ff <= csr_data[9:0];
            CSR_PIXEL_COLOR:   color_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective width: saturated, even
   always_comb begin
      cw_ext   = {1'b0, width_ff};
      max_ext  = 9'(MAX_WIDTH);
      clamp    = (cw_ext < max_ext) ? cw_ext : max_ext;
      wid      = {clamp[WW-1:1], 1'b0};
      line_off = LW'(wid) + LW'(wid >> 1);
      hgt      = {height_ff[9:1], 1'b0};
      end_sum  = {1'b0, x_ff} + {1'b0, w_ff};
      product  = (LW + 10)'(line_off) * (LW + 10)'(y_ff);
   end

   always_comb begin
      if (width_ff == '0 || height_ff == '0) chk = ST_INVALID_CANVAS;
      else if (x_ff >= 10'(wid))             chk = ST_BAD_X;
      else if (y_ff >= hgt)                  chk = ST_BAD_Y;
      else if (w_ff == '0)                   chk = ST_ZERO_LENGTH;
      else if (w_ff >= 10'(wid))             chk = ST_BAD_LENGTH;
      else if (end_sum > 11'(wid))           chk = ST_END_COLUMN;
      else                                   chk = ST_OK;
   end

   always_comb begin
      take_one = odd_ff || (rem_ff == XW'(1));
      rem_wide = {1'b0, rem_ff} - (take_one ? (XW + 1)'(1) : (XW + 1)'(2));
      if (odd_ff)                  nib = NIB_ODD;
      else if (rem_ff == XW'(1))   nib = NIB_EVEN;
      else                         nib = NIB_PAIR;
      dp_status.fail = (chk != ST_OK);
      dp_status.last = (rem_wide == '0);
   end

   always_comb begin
      err_rsp            = '0;
      err_rsp.status     = chk;
      err_rsp.last_write = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_payload.start_x;
         y_ff <= req_payload.row_y;
         w_ff <= req_payload.span_length;
      end
      if (cmd.check) begin
         prod_ff <= 18'(product);
         rem_ff  <= w_ff[XW-1:0];
         odd_ff  <= x_ff[0];
      end
      if (cmd.add_base) begin
         addr_ff <= prod_ff + 18'({x_ff[9:1], 1'b0}) + 18'(x_ff[9:1]);
      end
      if (cmd.emit_write) begin
         addr_ff <= addr_ff + 18'd3;
         rem_ff  <= rem_wide[XW-1:0];
         odd_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_error) begin
         rsp_ff <= err_rsp;
      end else if (cmd.emit_write) begin
         rsp_ff.status        <= ST_OK;
         rsp_ff.byte_address  <= addr_ff;
         rsp_ff.first_byte    <= color_ff[11:4];
         rsp_ff.middle_byte   <= {color_ff[3:0], color_ff[11:8]};
         rsp_ff.third_byte    <= color_ff[7:0];
         rsp_ff.nibble_enable <= nib;
         rsp_ff.last_write    <= dp_status.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_error | cmd.emit_write;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/packed_rgb444_span_fill_top.sv]
// Top level of the packed RGB444 span fill: sequencer plus datapath.
// Depends on prsf_pkg, prsf_ctrl, prsf_datapath and the assertion macro header.
//
//   channel  ports                          handshake
//   request  start, busy, req_payload       taken when start && !busy
//   result   rsp_strobe, rsp_payload        one result per strobe, no back-pressure
//   csr      csr_valid/ready/index/data     written when csr_valid && csr_ready
//
// A request is checked, and its line base multiplied out, in the cycle after
// it is taken; a failed check puts its single result out on the following cycle.
// A valid span then has the column offset added in S_BASE, after which the pair
// walker puts out one write per cycle. busy drops with the last result; csr_ready
// is high whenever busy is low. Synchronous reset clears the canvas registers, the
// result strobe and the sequencer.
`timescale 1ns / 1ps
`include "packed_rgb444_span_fill_top_macros.svh"

module packed_rgb444_span_fill_top
   import prsf_pkg::*;
#(
   parameter int MAX_WIDTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   assign csr_ready = !busy;

   prsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .busy      (busy),
      .cmd       (cmd)
   );

   prsf_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .dp_status   (dp_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   `PRSF_ASSERT_NEXT(a_take_sets_busy, clock, reset, start && !busy, busy)
   `PRSF_ASSERT_SAME(a_error_is_last, clock, reset, rsp_strobe && rsp_payload.status != ST_OK, rsp_payload.last_write)
   `PRSF_ASSERT_SAME(a_write_has_enable, clock, reset, rsp_strobe && rsp_payload.status == ST_OK, rsp_payload.nibble_enable != 6'd0)
   `PRSF_ASSERT_SAME(a_last_frees_block, clock, reset, rsp_strobe && rsp_payload.last_write, !busy)

endmodule
